// ===== hw/rtl/iir_direct_form_filter_top_defines.svh =====
// Assertion macros for the direct form I filter.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef IIR_DIRECT_FORM_FILTER_TOP_DEFINES_SVH
`define IIR_DIRECT_FORM_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset
`define IIR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("iir: same-cycle check failed");

// Next-cycle implication, masked during reset
`define IIR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("iir: next-cycle check failed");

`endif

// ===== hw/rtl/iir_pkg.sv =====
// Shared types and constants for the direct form I filter.
// No dependencies; imported by every module of the block.
package iir_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = 36;
   localparam int TAPS_W   = 3;
   localparam int TAP_IW   = 2;
   localparam int FRAC_SH  = 14;
   localparam int NUM_COEF = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [TAPS_W-1:0]          taps_type;
   typedef logic [TAP_IW-1:0]          tap_idx_type;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_FF0  = 3'd0,
      REG_FF1  = 3'd1,
      REG_FF2  = 3'd2,
      REG_FF3  = 3'd3,
      REG_FB1  = 3'd4,
      REG_FB2  = 3'd5,
      REG_FB3  = 3'd6,
      REG_TAPS = 3'd7
   } reg_idx_type;

   localparam coef_type B0_RESET   = coef_type'(18'sd16384);
   localparam taps_type TAPS_RESET = taps_type'(3'd4);

   // Rounding offset and saturation bound, Q.29
   localparam acc_type ROUND_OFS = acc_type'(36'sd8192);
   localparam acc_type SAT_HI    = acc_type'(36'sd536870912);
   localparam acc_type SAT_LO    = acc_type'(-36'sd536870912);
   localparam sample_type SMP_MAX = sample_type'(16'sh7fff);
   localparam sample_type SMP_MIN = sample_type'(16'sh8000);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_TAIL,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic        load;    // take the new sample, clear the accumulator
      logic        mul;     // issue one product
      tap_idx_type tap;     // tap of the product
      logic        fb;      // feedback product, subtracted
      logic        commit;  // round, update histories, fill the output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;       // output register can take a result this cycle
   } dp_status_type;

endpackage

// ===== hw/rtl/iir_csr.sv =====
// Configuration registers: coefficients and the tap count.
// Depends on iir_pkg.
module iir_csr #(
   parameter int MAX_TAPS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [iir_pkg::COEF_W-1:0]        csr_wdata,
   output iir_pkg::coef_type [3:0]           ff_coef,
   output iir_pkg::coef_type [3:0]           fb_coef,
   output iir_pkg::taps_type                 taps_eff
);
   import iir_pkg::*;

   coef_type [3:0] ff_ff;
   coef_type [3:1] fb_ff;
   taps_type       taps_ff;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         ff_ff   <= {coef_type'(0), coef_type'(0), coef_type'(0), B0_RESET};
         fb_ff   <= '0;
         taps_ff <= TAPS_RESET;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_FF0:  ff_ff[0] <= coef_type'(csr_wdata);
            REG_FF1:  ff_ff[1] <= coef_type'(csr_wdata);
            REG_FF2:  ff_ff[2] <= coef_type'(csr_wdata);
            REG_FF3:  ff_ff[3] <= coef_type'(csr_wdata);
            REG_FB1:  fb_ff[1] <= coef_type'(csr_wdata);
            REG_FB2:  fb_ff[2] <= coef_type'(csr_wdata);
            REG_FB3:  fb_ff[3] <= coef_type'(csr_wdata);
            REG_TAPS: taps_ff  <= csr_wdata[TAPS_W-1:0];
            default: ;
         endcase
      end
   end

   assign ff_coef = ff_ff;
   assign fb_coef = {fb_ff, coef_type'(0)};

   // Clamp the tap count to 1 .. MAX_TAPS
   always_comb begin
      if (taps_ff == '0) begin
         taps_eff = taps_type'(1);
      end else if (taps_ff > taps_type'(MAX_TAPS)) begin
         taps_eff = taps_type'(MAX_TAPS);
      end else begin
         taps_eff = taps_ff;
      end
   end

endmodule

// ===== hw/rtl/iir_ctrl.sv =====
// Sequencer for the shared multiply-accumulate: one product per cycle.
// Depends on iir_pkg.
module iir_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  iir_pkg::taps_type       taps_eff,
   input  iir_pkg::dp_status_type  status,
   output iir_pkg::dp_cmd_type     cmd
);
   import iir_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] last_step;
   logic [3:0] step_inc;

   // Products run from 0 to 2*T-2
   assign last_step = 3'(({1'b0, taps_eff} << 1) - 4'd2);
   assign step_inc  = {1'b0, step_ff} + 4'd1;

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            step_in = step_inc[2:0];
            if (step_ff == last_step) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Outputs: step 0 is b0*x, odd steps feedforward, even steps feedback
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.tap   = tap_idx_type'(step_inc >> 1);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MAC: begin
            cmd.mul = 1'b1;
            cmd.fb  = (step_ff != '0) && !step_ff[0];
         end
         ST_TAIL: ;
         ST_DONE: begin
            cmd.commit = status.out_free;
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/iir_dp.sv =====
// Datapath: sample histories, shared multiplier, accumulator, rounding
// and the output register. Depends on iir_pkg.
module iir_dp #(
   parameter int MAX_TAPS = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  iir_pkg::sample_type      req_sample_in,
   input  iir_pkg::coef_type [3:0]  ff_coef,
   input  iir_pkg::coef_type [3:0]  fb_coef,
   input  iir_pkg::dp_cmd_type      cmd,
   output iir_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output iir_pkg::sample_type      rsp_sample_out,
   output logic                     rsp_clipped
);
   import iir_pkg::*;

   localparam int HIST_D  = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
   localparam int HIST_IW = (HIST_D > 1) ? $clog2(HIST_D) : 1;

   sample_type [HIST_D-1:0] xh_ff;
   sample_type [HIST_D-1:0] yh_ff;
   sample_type  x_ff;
   prod_type    prod_ff, prod_in;
   logic        prod_vld_ff;
   logic        neg_ff;
   acc_type     acc_ff;
   acc_type     acc_rnd;
   sample_type  smp_sel;
   coef_type    coef_sel;
   tap_idx_type hist_sel;
   sample_type  y_in;
   logic        clip_in;
   sample_type  out_ff;
   logic        clip_ff;
   logic        rsp_valid_ff;

   // Select the operands of this product
   assign hist_sel = cmd.tap - tap_idx_type'(1);
   always_comb begin
      if (cmd.tap == '0) begin
         smp_sel = x_ff;
      end else if (cmd.fb) begin
         smp_sel = yh_ff[hist_sel[HIST_IW-1:0]];
      end else begin
         smp_sel = xh_ff[hist_sel[HIST_IW-1:0]];
      end
      coef_sel = cmd.fb ? fb_coef[cmd.tap] : ff_coef[cmd.tap];
   end

   assign prod_in = coef_sel * smp_sel;

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul;
      end
      prod_ff <= prod_in;
      neg_ff  <= cmd.fb;
   end

   // Take the sample, clear and accumulate
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= req_sample_in;
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= neg_ff ? acc_ff - acc_type'(prod_ff) : acc_ff + acc_type'(prod_ff);
      end
   end

   // Round to Q1.15 and saturate
   assign acc_rnd = acc_ff + ROUND_OFS;
   always_comb begin
      if (acc_rnd >= SAT_HI) begin
         y_in    = SMP_MAX;
         clip_in = 1'b1;
      end else if (acc_rnd < SAT_LO) begin
         y_in    = SMP_MIN;
         clip_in = 1'b1;
      end else begin
         y_in    = acc_rnd[FRAC_SH+SAMPLE_W-1:FRAC_SH];
         clip_in = 1'b0;
      end
   end

   // Advance the histories on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         xh_ff <= '0;
         yh_ff <= '0;
      end else if (cmd.commit) begin
         xh_ff[0] <= x_ff;
         yh_ff[0] <= y_in;
         for (int i = 1; i < HIST_D; i++) begin
            xh_ff[i] <= xh_ff[i-1];
            yh_ff[i] <= yh_ff[i-1];
         end
      end
   end

   // Output register: fill on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         out_ff  <= y_in;
         clip_ff <= clip_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = out_ff;
   assign rsp_clipped     = clip_ff;

endmodule

// ===== hw/rtl/iir_direct_form_filter_top.sv =====
// Direct form I IIR filter, Q1.15 samples, Q3.14 coefficients, up to 4 taps.
// Usage:
//   req_ channel takes one sample per item (req_sample_in); rsp_ channel
//   returns one filtered sample per item (rsp_sample_out, rsp_clipped).
//   Both use valid/ready; an item moves when valid and ready are high.
//   csr_we writes csr_wdata to register csr_index at once: b0..b3 at 0..3,
//   a1..a3 at 4..6, taps in use at 7. Write only while the block is idle.
// Sequence:
//   One shared 18x16 multiplier steps through 2*T-1 products, T being the
//   taps in use, then a tail state drains the product register and a done
//   state rounds and commits; rsp_valid is set by that commit. A new item
//   is taken only in the idle state, after the previous one has committed.
//   The output register lets the next item be accepted while a result waits.
// Reset:
//   Synchronous, active high. Clears both histories, loads b0 = 1.0, all
//   other coefficients zero and four taps. No clearing pass is needed.
// Stall:
//   A held result keeps the next item in its commit step until the output
//   register is taken; histories only advance at commit.
`include "iir_direct_form_filter_top_defines.svh"

module iir_direct_form_filter_top #(
   parameter int MAX_TAPS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  iir_pkg::sample_type          req_sample_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output iir_pkg::sample_type          rsp_sample_out,
   output logic                         rsp_clipped,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [iir_pkg::COEF_W-1:0]   csr_wdata
);
   import iir_pkg::*;

   coef_type [3:0] ff_coef;
   coef_type [3:0] fb_coef;
   taps_type       taps_eff;
   dp_cmd_type     cmd;
   dp_status_type  status;

   iir_csr #(.MAX_TAPS(MAX_TAPS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ff_coef   (ff_coef),
      .fb_coef   (fb_coef),
      .taps_eff  (taps_eff)
   );

   iir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .taps_eff  (taps_eff),
      .status    (status),
      .cmd       (cmd)
   );

   iir_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_sample_in  (req_sample_in),
      .ff_coef        (ff_coef),
      .fb_coef        (fb_coef),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

   // An accepted item blocks intake until its result is committed
   `IIR_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // No intake while products are being issued
   `IIR_ASSERT_NOW(a_no_intake_in_mac, cmd.mul, !req_ready && !cmd.commit)
   // A commit always presents a result next cycle
   `IIR_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid)

endmodule

// ===== tb/sv/iir_direct_form_filter_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the direct form I filter: follows register writes and accepted items,
// predicts each filtered sample and compares it with the result the block hands back.
// Depends on iir_pkg for the sample, coefficient, taps and register index types.
module iir_direct_form_filter_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  iir_pkg::sample_type          req_sample_in,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  iir_pkg::sample_type          rsp_sample_out,
   input  logic                         rsp_clipped,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [iir_pkg::COEF_W-1:0]   csr_wdata,
   output int                           pending_results,
   output int                           mismatch_count
);
   import iir_pkg::*;

   localparam int HIST_DEPTH  = 3;
   localparam int TAPS_LIMIT  = 4;
   localparam logic signed [47:0] HALF_LSB   = 48'sd8192;
   localparam logic signed [47:0] CLIP_BOUND = 48'sd536870912;
   localparam coef_type   UNITY_GAIN = coef_type'(18'sd16384);
   localparam taps_type   ALL_TAPS   = taps_type'(3'd4);
   localparam sample_type PEAK_POS   = sample_type'(16'sh7fff);
   localparam sample_type PEAK_NEG   = sample_type'(16'sh8000);

   typedef struct packed {
      sample_type sample;
      logic       clipped;
   } filtered_type;

   // Shadow of the coefficient registers; feedback index 0 stays unused
   coef_type   feedforward_q [TAPS_LIMIT];
   coef_type   feedback_q    [TAPS_LIMIT];
   taps_type   taps_q;
   sample_type x_hist [HIST_DEPTH];
   sample_type y_hist [HIST_DEPTH];

   filtered_type expected_samples [$];
   int           mismatches = 0;

   assign mismatch_count = mismatches;

   // Print one line and count it
   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Exact Q.29 sum of products, round half up to Q1.15, saturate, then advance histories
   function automatic filtered_type predict_filtered(input sample_type x);
      logic signed [47:0] acc;
      logic signed [47:0] coef_w;
      logic signed [47:0] data_w;
      logic signed [47:0] scaled;
      int                 taps;
      int                 k;
      filtered_type       res;
      if (taps_q == 0)
         taps = 1;
      else if (taps_q > TAPS_LIMIT)
         taps = TAPS_LIMIT;
      else
         taps = int'(taps_q);
      coef_w = feedforward_q[0];
      data_w = x;
      acc = coef_w * data_w;
      for (k = 1; k < taps; k++) begin
         coef_w = feedforward_q[k];
         data_w = x_hist[k-1];
         acc = acc + coef_w * data_w;
         coef_w = feedback_q[k];
         data_w = y_hist[k-1];
         acc = acc - coef_w * data_w;
      end
      acc = acc + HALF_LSB;
      if (acc >= CLIP_BOUND) begin
         res.sample  = PEAK_POS;
         res.clipped = 1'b1;
      end else if (acc < -CLIP_BOUND) begin
         res.sample  = PEAK_NEG;
         res.clipped = 1'b1;
      end else begin
         scaled      = acc >>> FRAC_SH;
         res.sample  = scaled[SAMPLE_W-1:0];
         res.clipped = 1'b0;
      end
      // Histories shift on every sample, whatever the taps in use
      for (k = HIST_DEPTH - 1; k > 0; k--) begin
         x_hist[k] = x_hist[k-1];
         y_hist[k] = y_hist[k-1];
      end
      x_hist[0] = x;
      y_hist[0] = res.sample;
      return res;
   endfunction

   always @(posedge clock) begin
      filtered_type want;
      int           k;
      if (reset) begin
         // Hold reset values: unity b0, four taps, empty histories
         for (k = 0; k < TAPS_LIMIT; k++) begin
            feedforward_q[k] = '0;
            feedback_q[k]    = '0;
         end
         feedforward_q[0] = UNITY_GAIN;
         taps_q = ALL_TAPS;
         for (k = 0; k < HIST_DEPTH; k++) begin
            x_hist[k] = '0;
            y_hist[k] = '0;
         end
         expected_samples.delete();
         pending_results <= 0;
      end else begin
         // Follow register writes
         if (csr_we) begin
            case (reg_idx_type'(csr_index))
               REG_FF0:  feedforward_q[0] = csr_wdata;
               REG_FF1:  feedforward_q[1] = csr_wdata;
               REG_FF2:  feedforward_q[2] = csr_wdata;
               REG_FF3:  feedforward_q[3] = csr_wdata;
               REG_FB1:  feedback_q[1]    = csr_wdata;
               REG_FB2:  feedback_q[2]    = csr_wdata;
               REG_FB3:  feedback_q[3]    = csr_wdata;
               REG_TAPS: taps_q           = csr_wdata[TAPS_W-1:0];
               default:  report_mismatch("register index unknown during a write");
            endcase
         end

         // Compare the returned item with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("result %0d with no item outstanding",
                                         rsp_sample_out));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want.sample)
                  report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                            rsp_sample_out, want.sample));
               if (rsp_clipped !== want.clipped)
                  report_mismatch($sformatf("clipped %0b, predicted %0b",
                                            rsp_clipped, want.clipped));
            end
         end

         // Predict for each accepted item, queued behind the older ones
         if (req_valid && req_ready)
            expected_samples.insert(expected_samples.size(),
                                    predict_filtered(req_sample_in));

         pending_results <= expected_samples.size();
      end
   end

endmodule

// ===== tb/sv/tb_iir_direct_form_filter_top.sv =====
`timescale 1ns / 1ps
// Top of the filter testbench: clock, reset, sample and register stimulus, receiver stalls.
// Depends on iir_pkg, the filter top level and iir_direct_form_filter_checker.
module tb_iir_direct_form_filter_top;
   import iir_pkg::*;

   localparam int       SETTLE_CYCLES = 20;
   localparam int       SETTINGS_PER_PHASE = 5;
   localparam coef_type COEF_MAX = coef_type'(18'sd131071);
   localparam coef_type COEF_MIN = coef_type'(-18'sd131072);
   localparam coef_type COEF_ONE = coef_type'(18'sd16384);
   localparam coef_type COEF_NIL = coef_type'(18'sd0);

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   sample_type          req_sample_in = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   sample_type          rsp_sample_out;
   logic                rsp_clipped;
   logic                csr_we = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [COEF_W-1:0]   csr_wdata = '0;
   int                  pending_results;
   int                  mismatch_count;

   int send_idle_pct = 13;
   int recv_idle_pct = 63;

   iir_direct_form_filter_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   iir_direct_form_filter_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_clipped     (rsp_clipped),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stall at random at the current rate
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one item, with a random gap first; returns at the edge that takes it
   task automatic offer_sample(input sample_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Drop valid, hold off until every result is back, then let the pipeline settle
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_idx_type idx, input logic [COEF_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Program every register; the taps word carries random upper bits
   task automatic load_coefficients(input coef_type b0, input coef_type b1,
                                    input coef_type b2, input coef_type b3,
                                    input coef_type a1, input coef_type a2,
                                    input coef_type a3, input taps_type taps);
      logic [COEF_W-1:0] taps_word;
      taps_word = COEF_W'($urandom);
      taps_word[TAPS_W-1:0] = taps;
      write_register(REG_FF0, b0);
      write_register(REG_FF1, b1);
      write_register(REG_FF2, b2);
      write_register(REG_FF3, b3);
      write_register(REG_FB1, a1);
      write_register(REG_FB2, a2);
      write_register(REG_FB3, a3);
      write_register(REG_TAPS, taps_word);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Gentle (stable), full range, or one of the corner values
   function automatic coef_type draw_coef(input int style, input bit is_feedback);
      case (style)
         0: begin
            if (is_feedback)
               return coef_type'(int'($urandom_range(6000)) - 3000);
            return coef_type'(int'($urandom_range(16384)) - 8192);
         end
         1: return coef_type'($urandom);
         default: begin
            case ($urandom_range(3))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return COEF_ONE;
               default: return COEF_NIL;
            endcase
         end
      endcase
   endfunction

   function automatic sample_type draw_sample();
      case ($urandom_range(15))
         0: return sample_type'(16'sh7fff);
         1: return sample_type'(16'sh8000);
         2: return sample_type'(int'($urandom_range(64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic load_random_filter();
      int       pick;
      int       style;
      taps_type taps;
      pick  = $urandom_range(99);
      style = (pick < 60) ? 0 : ((pick < 85) ? 1 : 2);
      // Mostly legal tap counts, now and then the clamped ones
      if ($urandom_range(99) < 80) begin
         taps = taps_type'($urandom_range(4, 1));
      end else begin
         pick = $urandom_range(3);
         taps = (pick == 0) ? taps_type'(0) : taps_type'(pick + 4);
      end
      load_coefficients(draw_coef(style, 1'b0), draw_coef(style, 1'b0),
                        draw_coef(style, 1'b0), draw_coef(style, 1'b0),
                        draw_coef(style, 1'b1), draw_coef(style, 1'b1),
                        draw_coef(style, 1'b1), taps);
   endtask

   initial begin
      int phase;
      int setting;
      int n_items;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients pass samples through: field extremes and bit patterns
      offer_sample(16'sh7fff);
      offer_sample(16'sh8000);
      offer_sample(16'sh0000);
      offer_sample(16'sh0001);
      offer_sample(16'shffff);
      offer_sample(16'sh5555);
      offer_sample(16'shaaaa);

      // Largest gains of both signs: saturation high and low
      wait_for_quiet();
      load_coefficients(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
                        COEF_MAX, COEF_MIN, COEF_MAX, taps_type'(4));
      offer_sample(16'sh7fff);
      offer_sample(16'sh8000);
      offer_sample(16'sh0000);
      offer_sample(16'sh0064);
      offer_sample(16'shff9c);

      // Zero taps act as one; the other coefficients must have no effect
      wait_for_quiet();
      load_coefficients(COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX,
                        COEF_MIN, COEF_MIN, COEF_MIN, taps_type'(0));
      offer_sample(16'sh8000);
      offer_sample(16'sh7fff);
      offer_sample(16'sh0001);
      offer_sample(16'shffff);

      // Tap counts above the maximum act as four
      wait_for_quiet();
      load_coefficients(coef_type'(8192), coef_type'(8192), coef_type'(4096),
                        coef_type'(-4096), coef_type'(-4096), coef_type'(2048),
                        coef_type'(1024), taps_type'(7));
      offer_sample(16'sh4000);
      offer_sample(16'shc000);
      offer_sample(16'sh1234);
      offer_sample(16'sh7fff);

      // Two taps with feedback: histories keep shifting beyond the taps in use
      wait_for_quiet();
      load_coefficients(COEF_ONE, coef_type'(-8192), COEF_MAX, COEF_MIN,
                        coef_type'(8192), COEF_MAX, COEF_MIN, taps_type'(2));
      offer_sample(16'sh2000);
      offer_sample(16'sh8000);
      offer_sample(16'sh0003);

      // Random filters under three stall patterns
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct <= 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct <= 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
            wait_for_quiet();
            load_random_filter();
            n_items = $urandom_range(120, 80);
            repeat (n_items) offer_sample(draw_sample());
         end
      end

      wait_for_quiet();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog well beyond the slowest correct run
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
